### src/assert_macros.svh
// Assertion macros used by the RTL of the cycle detector.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

### src/dcd_pkg.sv
// Package for the directed cycle detector: sizes, command codes, item types.
// No dependencies; used by the detector top module and the testbench.
package dcd_pkg;

    localparam int VERTICES = 16;
    localparam int VERTEX_W = 4;
    localparam int COUNT_W  = 5;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef struct packed {
        logic                cmd;
        logic [VERTEX_W-1:0] row_index;
        logic [VERTICES-1:0] row_bits;
    } in_item_t;

    typedef struct packed {
        logic                found;
        logic [VERTEX_W-1:0] vertex;
        logic                last;
    } out_item_t;

    // One saved level of the search: its vertex and the next neighbour to try
    typedef struct packed {
        logic [VERTEX_W-1:0] vertex;
        logic [COUNT_W-1:0]  cursor;
    } stack_entry_t;

endpackage

### src/directed_cycle_detect_dfs_unit.sv
// Directed-graph cycle detector, depth-first search over an adjacency store.
// Depends on dcd_pkg, dcd_ram and assert_macros.svh.
//
// A load item (cmd 0) writes one adjacency row. A search item (cmd 1)
// walks the graph from roots 0 upward, neighbours in ascending order, one neighbour per
// cycle; each push passes through ST_LOADROW and each pop through ST_POPRD and ST_LOADROW,
// as the adjacency row and the saved stack level come out of RAMs with registered read
// data. Result items then go out while the output is free, each path entry below the top
// first read back from the stack RAM.
// The adjacency store reads as empty after reset through per-row valid flags, so no clearing
// pass is needed. The output register lets the next item be accepted while the last result
// still waits. vertex_count may only be written while no search is in progress.
`include "assert_macros.svh"

module directed_cycle_detect_dfs_unit
    import dcd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [COUNT_W-1:0] cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_item_t           in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output out_item_t          out_data
);

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_ROOT     = 10'b00_0000_0010,
        ST_LOADROW  = 10'b00_0000_0100,
        ST_SCAN     = 10'b00_0000_1000,
        ST_POPRD    = 10'b00_0001_0000,
        ST_EMIT_RD  = 10'b00_0010_0000,
        ST_EMIT_LD  = 10'b00_0100_0000,
        ST_EMIT_TOP = 10'b00_1000_0000,
        ST_EMIT_END = 10'b01_0000_0000,
        ST_NONE     = 10'b10_0000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [COUNT_W-1:0]  n_reg, n_next;
    logic [VERTICES-1:0] adj_valid_reg, adj_valid_next;
    logic [VERTICES-1:0] visited_reg, visited_next;
    logic [VERTICES-1:0] on_path_reg, on_path_next;
    logic [COUNT_W-1:0]  depth_reg, depth_next;
    logic [COUNT_W-1:0]  root_reg, root_next;
    logic [VERTEX_W-1:0] v_reg, v_next;
    logic [COUNT_W-1:0]  i_reg, i_next;
    logic [VERTEX_W-1:0] nb_reg, nb_next;
    logic [VERTICES-1:0] row_reg, row_next;
    logic                adj_hit_reg, adj_hit_next;
    logic [VERTEX_W-1:0] emit_k_reg, emit_k_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_data_reg, out_data_next;

    logic                adj_we;
    logic [VERTEX_W-1:0] adj_raddr;
    logic [VERTICES-1:0] adj_rdata;
    logic                stk_we;
    logic [VERTEX_W-1:0] stk_waddr;
    stack_entry_t        stk_wdata;
    logic [VERTEX_W-1:0] stk_raddr;
    stack_entry_t        stk_rdata;

    logic                out_free;
    logic [COUNT_W-1:0]  depth_m1;
    logic [VERTEX_W-1:0] i_idx;
    logic [VERTEX_W-1:0] root_idx;

    assign out_free  = !out_valid_reg || out_ready;
    assign depth_m1  = depth_reg - COUNT_W'(1);
    assign i_idx     = i_reg[VERTEX_W-1:0];
    assign root_idx  = root_reg[VERTEX_W-1:0];
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    dcd_ram #(.WIDTH(VERTICES), .DEPTH(VERTICES)) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (in_data.row_index),
        .wdata (in_data.row_bits),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    // Saved levels below the top of the path; the top level lives in v_reg / i_reg.
    // A level is written on push and read back on a pop or when the path is emitted.
    dcd_ram #(.WIDTH($bits(stack_entry_t)), .DEPTH(VERTICES)) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = cfg_write ? cfg_data : count_reg;
        n_next         = n_reg;
        adj_valid_next = adj_valid_reg;
        visited_next   = visited_reg;
        on_path_next   = on_path_reg;
        depth_next     = depth_reg;
        root_next      = root_reg;
        v_next         = v_reg;
        i_next         = i_reg;
        nb_next        = nb_reg;
        row_next       = row_reg;
        adj_hit_next   = adj_hit_reg;
        emit_k_next    = emit_k_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        adj_we         = 1'b0;
        adj_raddr      = v_reg;
        stk_we         = 1'b0;
        stk_waddr      = depth_m1[VERTEX_W-1:0];
        stk_wdata      = '{vertex: v_reg, cursor: i_reg + COUNT_W'(1)};
        stk_raddr      = emit_k_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.cmd == CMD_LOAD)
                    begin
                        adj_we = 1'b1;
                        adj_valid_next[in_data.row_index] = 1'b1;
                    end
                    else
                    begin
                        visited_next = '0;
                        on_path_next = '0;
                        depth_next   = '0;
                        root_next    = '0;
                        n_next       = (count_reg > COUNT_W'(VERTICES)) ?
                                       COUNT_W'(VERTICES) : count_reg;
                        state_next   = ST_ROOT;
                    end
                end
            end

            ST_ROOT:
            begin
                if (root_reg >= n_reg)
                begin
                    state_next = ST_NONE;
                end
                else if (visited_reg[root_idx])
                begin
                    root_next = root_reg + COUNT_W'(1);
                end
                else
                begin
                    visited_next[root_idx] = 1'b1;
                    on_path_next[root_idx] = 1'b1;
                    v_next       = root_idx;
                    i_next       = '0;
                    depth_next   = COUNT_W'(1);
                    adj_raddr    = root_idx;
                    adj_hit_next = adj_valid_reg[root_idx];
                    state_next   = ST_LOADROW;
                end
            end

            ST_LOADROW:
            begin
                row_next   = adj_hit_reg ? adj_rdata : '0;
                state_next = ST_SCAN;
            end

            ST_SCAN:
            begin
                if (i_reg >= n_reg)
                begin
                    // all neighbours tried: leave this vertex
                    on_path_next[v_reg] = 1'b0;
                    depth_next = depth_m1;
                    if (depth_reg == COUNT_W'(1))
                    begin
                        root_next  = root_reg + COUNT_W'(1);
                        state_next = ST_ROOT;
                    end
                    else
                    begin
                        stk_raddr  = VERTEX_W'(depth_reg - COUNT_W'(2));
                        state_next = ST_POPRD;
                    end
                end
                else if (!row_reg[i_idx])
                begin
                    i_next = i_reg + COUNT_W'(1);
                end
                else if (!visited_reg[i_idx])
                begin
                    if (depth_reg < COUNT_W'(VERTICES))
                    begin
                        stk_we = 1'b1;
                        visited_next[i_idx] = 1'b1;
                        on_path_next[i_idx] = 1'b1;
                        v_next       = i_idx;
                        i_next       = '0;
                        depth_next   = depth_reg + COUNT_W'(1);
                        adj_raddr    = i_idx;
                        adj_hit_next = adj_valid_reg[i_idx];
                        state_next   = ST_LOADROW;
                    end
                    else
                    begin
                        i_next = i_reg + COUNT_W'(1);
                    end
                end
                else if (on_path_reg[i_idx])
                begin
                    // back edge closes a cycle
                    nb_next     = i_idx;
                    emit_k_next = '0;
                    state_next  = (depth_reg == COUNT_W'(1)) ? ST_EMIT_TOP : ST_EMIT_RD;
                end
                else
                begin
                    i_next = i_reg + COUNT_W'(1);
                end
            end

            ST_POPRD:
            begin
                v_next       = stk_rdata.vertex;
                i_next       = stk_rdata.cursor;
                adj_raddr    = stk_rdata.vertex;
                adj_hit_next = adj_valid_reg[stk_rdata.vertex];
                state_next   = ST_LOADROW;
            end

            ST_EMIT_RD:
            begin
                // read only once the output slot is free, so the data can land next cycle
                if (out_free)
                begin
                    stk_raddr  = emit_k_reg;
                    state_next = ST_EMIT_LD;
                end
            end

            ST_EMIT_LD:
            begin
                out_valid_next = 1'b1;
                out_data_next  = '{found: 1'b1, vertex: stk_rdata.vertex, last: 1'b0};
                emit_k_next    = emit_k_reg + VERTEX_W'(1);
                if (COUNT_W'(emit_k_reg) + COUNT_W'(1) == depth_m1)
                begin
                    state_next = ST_EMIT_TOP;
                end
                else
                begin
                    state_next = ST_EMIT_RD;
                end
            end

            ST_EMIT_TOP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{found: 1'b1, vertex: v_reg, last: 1'b0};
                    state_next     = ST_EMIT_END;
                end
            end

            ST_EMIT_END:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{found: 1'b1, vertex: nb_reg, last: 1'b1};
                    state_next     = ST_IDLE;
                end
            end

            ST_NONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{found: 1'b0, vertex: '0, last: 1'b1};
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= COUNT_W'(VERTICES);
            adj_valid_reg <= '0;
            visited_reg   <= '0;
            on_path_reg   <= '0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            adj_valid_reg <= adj_valid_next;
            visited_reg   <= visited_next;
            on_path_reg   <= on_path_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        root_reg     <= root_next;
        v_reg        <= v_next;
        i_reg        <= i_next;
        nb_reg       <= nb_next;
        row_reg      <= row_next;
        adj_hit_reg  <= adj_hit_next;
        emit_k_reg   <= emit_k_next;
        out_data_reg <= out_data_next;
    end

    `ASSERT_ALWAYS(a_path_in_visited, clk, rst_n, (on_path_reg & ~visited_reg) == '0, "on-path vertex not visited")
    `ASSERT_ALWAYS(a_path_count, clk, rst_n, (state_reg == ST_SCAN) |-> ($countones(on_path_reg) == int'(depth_reg)), "path marks disagree with stack depth")
    `ASSERT_NEVER(a_emit_slot_free, clk, rst_n, (state_reg == ST_EMIT_LD) && out_valid_reg, "stack read data arrives with output slot busy")
    `ASSERT_ALWAYS(a_search_start, clk, rst_n, (in_valid && in_ready && (in_data.cmd == CMD_SEARCH)) |=> (state_reg == ST_ROOT), "search item did not start a search")
    `ASSERT_NEVER(a_depth_bound, clk, rst_n, depth_reg > COUNT_W'(VERTICES), "stack depth beyond vertex count")

endmodule

### src/dcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the adjacency store and the path stack.
module dcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### test/tb_top.sv
// Testbench for directed_cycle_detect_dfs_unit: loads graphs, runs searches and checks each
// result item against a depth-first search worked out in the bench. Depends on dcd_pkg.
`timescale 1ns / 1ps

module tb_top;
    import dcd_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 8;
    localparam int SETTLE       = 16;
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 135;
    localparam int IDLE_PCT     = 20;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [COUNT_W-1:0] cfg_data;
    logic               in_valid;
    logic               in_ready;
    in_item_t           in_data;
    logic               out_valid;
    logic               out_ready;
    out_item_t          out_data;

    // bench copy of the graph and the register
    logic [VERTICES-1:0] adjacency_model [VERTICES];
    logic [COUNT_W-1:0]  vertex_count_model;
    out_item_t           pending_answers [$];
    out_item_t           oldest_answer;
    int                  mismatch_count;
    int                  quiet_cycles;
    bit                  steady_flow;

    directed_cycle_detect_dfs_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Depth-first search from roots in ascending order; queues the answer items
    function automatic void predict_cycle_search();
        int                  n;
        int                  depth;
        int                  top;
        int                  v;
        int                  i;
        int                  path [VERTICES];
        int                  cursor [VERTICES];
        logic [VERTICES-1:0] seen;
        logic [VERTICES-1:0] on_path;
        out_item_t           answer;
        n = (vertex_count_model > VERTICES) ? VERTICES : int'(vertex_count_model);
        seen = '0;
        on_path = '0;
        depth = 0;
        for (int root = 0; root < n; root++)
        begin
            if (seen[root])
                continue;
            seen[root] = 1'b1;
            on_path[root] = 1'b1;
            path[0] = root;
            cursor[0] = 0;
            depth = 1;
            while (depth > 0)
            begin
                top = depth - 1;
                v = path[top];
                i = cursor[top];
                if (i >= n)
                begin
                    on_path[v] = 1'b0;
                    depth--;
                    continue;
                end
                cursor[top] = i + 1;
                if (!adjacency_model[v][i])
                    continue;
                if (!seen[i])
                begin
                    seen[i] = 1'b1;
                    on_path[i] = 1'b1;
                    path[depth] = i;
                    cursor[depth] = 0;
                    depth++;
                    continue;
                end
                if (on_path[i])
                begin
                    for (int k = 0; k < depth; k++)
                    begin
                        answer.found = 1'b1;
                        answer.vertex = VERTEX_W'(path[k]);
                        answer.last = 1'b0;
                        pending_answers.insert(pending_answers.size(), answer);
                    end
                    answer.found = 1'b1;
                    answer.vertex = VERTEX_W'(i);
                    answer.last = 1'b1;
                    pending_answers.insert(pending_answers.size(), answer);
                    return;
                end
            end
        end
        answer.found = 1'b0;
        answer.vertex = '0;
        answer.last = 1'b1;
        pending_answers.insert(pending_answers.size(), answer);
    endfunction

    task automatic report_mismatch(string what, int want, int got);
        $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
        mismatch_count++;
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(in_item_t item);
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data = item;
        do
            @(posedge clk);
        while (!in_ready);
        if (item.cmd == CMD_LOAD)
            adjacency_model[item.row_index] = item.row_bits;
        else
            predict_cycle_search();
        @(negedge clk);
    endtask

    task automatic send_load(int row, logic [VERTICES-1:0] bits);
        in_item_t item;
        item.cmd = CMD_LOAD;
        item.row_index = VERTEX_W'(row);
        item.row_bits = bits;
        send_item(item);
    endtask

    task automatic send_search();
        in_item_t item;
        item.cmd = CMD_SEARCH;
        item.row_index = VERTEX_W'($urandom);
        item.row_bits = VERTICES'($urandom);
        send_item(item);
    endtask

    // Waits until every answer has come back and the block has settled
    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending_answers.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_vertex_count(int count);
        wait_idle();
        cfg_write = 1'b1;
        cfg_data = COUNT_W'(count);
        @(negedge clk);
        cfg_write = 1'b0;
        vertex_count_model = COUNT_W'(count);
    endtask

    task automatic test_empty_graph();
        send_search();
    endtask

    task automatic test_self_loops();
        send_load(VERTICES - 1, 16'h8000);
        send_search();
        send_load(0, 16'hFFFF);
        send_search();
    endtask

    // ring through every vertex: longest possible answer
    task automatic test_full_ring();
        for (int v = 0; v < VERTICES; v++)
            send_load(v, VERTICES'(1) << ((v + 1) % VERTICES));
        send_search();
    endtask

    // ring still loaded: saturation, no vertices, one vertex, ring edge cut off
    task automatic test_vertex_count_limits();
        set_vertex_count(31);
        send_search();
        set_vertex_count(0);
        send_search();
        set_vertex_count(1);
        send_search();
        set_vertex_count(15);
        send_search();
    endtask

    task automatic test_random_graphs();
        int                  sent;
        int                  round;
        int                  n;
        int                  kind;
        int                  pick;
        int                  tmp;
        int                  v;
        int                  order [VERTICES];
        int                  rank [VERTICES];
        logic [VERTICES-1:0] in_use;
        logic [VERTICES-1:0] forward;
        logic [VERTICES-1:0] row;
        sent = 0;
        round = 0;
        while (sent < RANDOM_ITEMS)
        begin
            round++;
            steady_flow = (round >= 6 && round < 10);
            if (round % 4 == 1)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    set_vertex_count(0);
                else if (pick == 1)
                    set_vertex_count($urandom_range(VERTICES + 1, 31));
                else if (pick == 2)
                    set_vertex_count(VERTICES);
                else
                    set_vertex_count($urandom_range(1, 8));
            end
            n = (vertex_count_model > VERTICES) ? VERTICES : int'(vertex_count_model);
            in_use = (n >= VERTICES) ? '1 : VERTICES'((1 << n) - 1);
            for (int j = 0; j < n; j++)
                order[j] = j;
            for (int j = n - 1; j > 0; j--)
            begin
                pick = $urandom_range(0, j);
                tmp = order[j];
                order[j] = order[pick];
                order[pick] = tmp;
            end
            for (int j = 0; j < n; j++)
                rank[order[j]] = j;
            // 0: acyclic, 1: acyclic plus a back edge, 2: sparse, 3: dense
            kind = $urandom_range(0, 3);
            for (v = 0; v < n; v++)
            begin
                forward = '0;
                for (int w = 0; w < n; w++)
                    if (rank[w] > rank[v])
                        forward[w] = 1'b1;
                case (kind) inside
                    0, 1: row = VERTICES'($urandom) & VERTICES'($urandom)
                              & (forward | ~in_use);
                    2:    row = VERTICES'($urandom) & VERTICES'($urandom)
                              & VERTICES'($urandom);
                    default: row = VERTICES'($urandom) | VERTICES'($urandom);
                endcase
                send_load(v, row);
                sent++;
            end
            if (kind == 1 && n > 0)
            begin
                v = $urandom_range(0, n - 1);
                pick = order[$urandom_range(0, rank[v])];
                send_load(v, adjacency_model[v] | (VERTICES'(1) << pick));
                sent++;
            end
            // stray row write, may land inside the graph
            if ($urandom_range(0, 99) < 25)
            begin
                send_load($urandom_range(0, VERTICES - 1), VERTICES'($urandom));
                sent++;
            end
            send_search();
            sent++;
            if ($urandom_range(0, 99) < 10)
            begin
                send_search();
                sent++;
            end
        end
        steady_flow = 1'b0;
    endtask

    always @(negedge clk)
        out_ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_answers.size() == 0)
                report_mismatch("unexpected item, vertex", -1, out_data.vertex);
            else
            begin
                oldest_answer = pending_answers.pop_front();
                if (out_data.found !== oldest_answer.found)
                    report_mismatch("found", oldest_answer.found, out_data.found);
                if (out_data.vertex !== oldest_answer.vertex)
                    report_mismatch("vertex", oldest_answer.vertex, out_data.vertex);
                if (out_data.last !== oldest_answer.last)
                    report_mismatch("last", oldest_answer.last, out_data.last);
            end
        end
    end

    // nothing accepted on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        mismatch_count = 0;
        quiet_cycles = 0;
        steady_flow = 1'b0;
        vertex_count_model = COUNT_W'(VERTICES);
        for (int v = 0; v < VERTICES; v++)
            adjacency_model[v] = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_graph();
        test_self_loops();
        test_full_ring();
        test_vertex_count_limits();
        test_random_graphs();
        wait_idle();

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
